// File: rtl/dptt_pkg.sv
// package for the depth-preferred transposition table
// holds the entry layout, field codes, command/status structs and the score saturation helper
package dptt_pkg;

    localparam int ENTRY_COUNT_LOG2_DEFAULT = 16;

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 32;
    localparam int SCORE_W = 16;
    localparam int KIND_W  = 2;
    localparam int DEPTH_W = 7;
    localparam int PLY_W   = 7;
    localparam int THR_W   = 15;
    localparam int SIZE_W  = 5;
    localparam int CFG_W   = 15;
    localparam int WIDE_W  = SCORE_W + 2;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_PROBE  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd3;

    localparam logic CFG_MATE_THRESHOLD = 1'b0;
    localparam logic CFG_SIZE_LOG2      = 1'b1;

    localparam logic signed [WIDE_W-1:0] SCORE_MAX = 18'sd32767;
    localparam logic signed [WIDE_W-1:0] SCORE_MIN = -18'sd32767;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [KIND_W-1:0]         kind;
        logic [DEPTH_W-1:0]        depth;
    } entry_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] c;
        begin
            if (v > SCORE_MAX)
            begin
                c = SCORE_MAX;
            end
            else if (v < SCORE_MIN)
            begin
                c = SCORE_MIN;
            end
            else
            begin
                c = v;
            end
            return c[SCORE_W-1:0];
        end
    endfunction

endpackage

// File: rtl/dptt_ctrl.sv
// controller for the transposition table: clearing sweep, load, execute
// uses dptt_pkg command and status structs
module dptt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_stall,
    input  dptt_pkg::status_t status,
    output dptt_pkg::cmd_t   cmd,
    output logic             in_stall,
    output logic             out_valid
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execute");

    a_exec_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && !out_free |=> (state_reg == S_EXEC) && out_valid_reg)
        else $error("execute left while output busy");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result without execute");

endmodule

// File: rtl/dptt_datapath.sv
// datapath for the transposition table: config registers, entry memory,
// lookup, replacement decision and score adjustment; uses dptt_pkg
module dptt_datapath #(
    parameter int ENTRY_COUNT_LOG2 = dptt_pkg::ENTRY_COUNT_LOG2_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dptt_pkg::cmd_t                       cmd,
    output dptt_pkg::status_t                    status,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [dptt_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 func,
    input  logic [dptt_pkg::KEY_W-1:0]           position_key,
    input  logic [dptt_pkg::DEPTH_W-1:0]         search_depth,
    input  logic signed [dptt_pkg::SCORE_W-1:0]  score_in,
    input  logic [dptt_pkg::KIND_W-1:0]          bound_kind,
    input  logic [dptt_pkg::MOVE_W-1:0]          best_move,
    input  logic [dptt_pkg::PLY_W-1:0]           ply,
    input  logic signed [dptt_pkg::SCORE_W-1:0]  alpha,
    input  logic signed [dptt_pkg::SCORE_W-1:0]  beta,
    output logic                                 key_match,
    output logic                                 cutoff,
    output logic [dptt_pkg::MOVE_W-1:0]          move_out,
    output logic signed [dptt_pkg::SCORE_W-1:0]  score_out
);

    localparam int AW    = ENTRY_COUNT_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam int WW    = dptt_pkg::WIDE_W;

    dptt_pkg::entry_t mem [DEPTH];

    logic [dptt_pkg::THR_W-1:0]  thr_reg;
    logic [dptt_pkg::SIZE_W-1:0] size_reg;
    logic [AW-1:0]               clr_cnt_reg;

    logic                                func_reg;
    logic [dptt_pkg::KEY_W-1:0]          key_reg;
    logic [dptt_pkg::DEPTH_W-1:0]        depth_reg;
    logic signed [dptt_pkg::SCORE_W-1:0] score_reg;
    logic [dptt_pkg::KIND_W-1:0]         kind_reg;
    logic [dptt_pkg::MOVE_W-1:0]         move_reg;
    logic [dptt_pkg::PLY_W-1:0]          ply_reg;
    logic signed [dptt_pkg::SCORE_W-1:0] alpha_reg;
    logic signed [dptt_pkg::SCORE_W-1:0] beta_reg;
    logic [AW-1:0]                       idx_reg;
    dptt_pkg::entry_t                    rd_reg;

    logic                                match_reg;
    logic                                cut_reg;
    logic [dptt_pkg::MOVE_W-1:0]         mv_reg;
    logic signed [dptt_pkg::SCORE_W-1:0] sout_reg;

    logic [AW-1:0]                       idx;
    logic                                hit;
    logic                                wr_en;
    dptt_pkg::entry_t                    wr_entry;
    logic signed [WW-1:0]                thr_w;
    logic signed [WW-1:0]                ply_w;
    logic signed [WW-1:0]                rec_w;
    logic signed [WW-1:0]                rec_adj;
    logic signed [WW-1:0]                st_w;
    logic signed [WW-1:0]                st_adj;
    logic                                match_next;
    logic                                cut_next;
    logic [dptt_pkg::MOVE_W-1:0]         mv_next;
    logic signed [dptt_pkg::SCORE_W-1:0] sout_next;

    always_comb
    begin
        for (int i = 0; i < AW; i++)
        begin
            idx[i] = position_key[i] && (dptt_pkg::SIZE_W'(i) < size_reg);
        end
    end

    assign status.clear_last = &clr_cnt_reg;

    assign thr_w = WW'(thr_reg);
    assign ply_w = WW'(ply_reg);
    assign rec_w = WW'(score_reg);
    assign st_w  = WW'(rd_reg.score);

    assign hit = (rd_reg.kind != dptt_pkg::KIND_EMPTY) && (rd_reg.key == key_reg);

    always_comb
    begin
        priority if (rec_w > thr_w)
        begin
            rec_adj = rec_w + ply_w;
        end
        else if (rec_w < -thr_w)
        begin
            rec_adj = rec_w - ply_w;
        end
        else
        begin
            rec_adj = rec_w;
        end
        priority if (st_w > thr_w)
        begin
            st_adj = st_w - ply_w;
        end
        else if (st_w < -thr_w)
        begin
            st_adj = st_w + ply_w;
        end
        else
        begin
            st_adj = st_w;
        end
    end

    always_comb
    begin
        wr_en          = cmd.exec && (func_reg == dptt_pkg::FUNC_RECORD)
                         && !(hit && (rd_reg.depth > depth_reg));
        wr_entry.key   = key_reg;
        wr_entry.move  = move_reg;
        wr_entry.score = dptt_pkg::sat_score(rec_adj);
        wr_entry.kind  = kind_reg;
        wr_entry.depth = depth_reg;
    end

    always_comb
    begin
        match_next = 1'b0;
        cut_next   = 1'b0;
        mv_next    = '0;
        sout_next  = '0;
        if ((func_reg == dptt_pkg::FUNC_PROBE) && hit)
        begin
            match_next = 1'b1;
            mv_next    = rd_reg.move;
            if (rd_reg.depth >= depth_reg)
            begin
                priority if (rd_reg.kind == dptt_pkg::KIND_EXACT)
                begin
                    cut_next  = 1'b1;
                    sout_next = dptt_pkg::sat_score(st_adj);
                end
                else if ((rd_reg.kind == dptt_pkg::KIND_UPPER) && (rd_reg.score <= alpha_reg))
                begin
                    cut_next  = 1'b1;
                    sout_next = alpha_reg;
                end
                else if ((rd_reg.kind == dptt_pkg::KIND_LOWER) && (rd_reg.score >= beta_reg))
                begin
                    cut_next  = 1'b1;
                    sout_next = beta_reg;
                end
                else
                begin
                    cut_next  = 1'b0;
                    sout_next = '0;
                end
            end
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[idx_reg] <= wr_entry;
        end
        if (cmd.load)
        begin
            rd_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            key_reg   <= position_key;
            depth_reg <= search_depth;
            score_reg <= score_in;
            kind_reg  <= bound_kind;
            move_reg  <= best_move;
            ply_reg   <= ply;
            alpha_reg <= alpha;
            beta_reg  <= beta;
            idx_reg   <= idx;
        end
        if (cmd.exec)
        begin
            match_reg <= match_next;
            cut_reg   <= cut_next;
            mv_reg    <= mv_next;
            sout_reg  <= sout_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= dptt_pkg::THR_W'(29000);
            size_reg    <= dptt_pkg::SIZE_W'(16);
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == dptt_pkg::CFG_MATE_THRESHOLD))
            begin
                thr_reg <= cfg_data[dptt_pkg::THR_W-1:0];
            end
            if (cfg_we && (cfg_index == dptt_pkg::CFG_SIZE_LOG2))
            begin
                size_reg <= cfg_data[dptt_pkg::SIZE_W-1:0];
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign key_match = match_reg;
    assign cutoff    = cut_reg;
    assign move_out  = mv_reg;
    assign score_out = sout_reg;

endmodule

// File: rtl/depth_preferred_transposition_table_top.sv
// top level of the depth-preferred transposition table
// instantiates dptt_ctrl and dptt_datapath; uses dptt_pkg
//
// usage:
//   input channel in_valid / in_stall carries one item: func selects record or
//   probe, with key, depth, score, bound kind, move, ply and the alpha/beta window.
//   output channel out_valid / out_stall carries one result item per input item
//   (key_match, cutoff, move_out, score_out; all zero for a record).
//   an item goes from acceptance to result through the registered read of
//   the entry memory, then compare, replacement and write-back on its single
//   port. one item is in flight at a time, so a new item is accepted only
//   once the last one has left execute.
//   after reset the entry memory is swept clear, one entry a cycle, through all
//   2**ENTRY_COUNT_LOG2 entries; in_stall is high during the sweep.
//   config writes (cfg_we, cfg_index, cfg_data) take effect at once.
//   when the receiver stalls, the result holds in the output register; a new
//   item is still accepted and waits in execute until the register frees.
module depth_preferred_transposition_table_top #(
    parameter int ENTRY_COUNT_LOG2 = dptt_pkg::ENTRY_COUNT_LOG2_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [dptt_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic [dptt_pkg::KEY_W-1:0]           position_key,
    input  logic [dptt_pkg::DEPTH_W-1:0]         search_depth,
    input  logic signed [dptt_pkg::SCORE_W-1:0]  score_in,
    input  logic [dptt_pkg::KIND_W-1:0]          bound_kind,
    input  logic [dptt_pkg::MOVE_W-1:0]          best_move,
    input  logic [dptt_pkg::PLY_W-1:0]           ply,
    input  logic signed [dptt_pkg::SCORE_W-1:0]  alpha,
    input  logic signed [dptt_pkg::SCORE_W-1:0]  beta,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 key_match,
    output logic                                 cutoff,
    output logic [dptt_pkg::MOVE_W-1:0]          move_out,
    output logic signed [dptt_pkg::SCORE_W-1:0]  score_out
);

    dptt_pkg::cmd_t    cmd;
    dptt_pkg::status_t status;

    dptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    dptt_datapath #(
        .ENTRY_COUNT_LOG2 (ENTRY_COUNT_LOG2)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .position_key (position_key),
        .search_depth (search_depth),
        .score_in     (score_in),
        .bound_kind   (bound_kind),
        .best_move    (best_move),
        .ply          (ply),
        .alpha        (alpha),
        .beta         (beta),
        .key_match    (key_match),
        .cutoff       (cutoff),
        .move_out     (move_out),
        .score_out    (score_out)
    );

endmodule
